/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked at every clock edge outside reset.
`define RSP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("rsp check failed");
// Condition in one cycle implies a condition in the next.
`define RSP_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("rsp check failed");
`else
`define RSP_ASSERT(lbl, clk, rst, prop)
`define RSP_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

/* hdl/rsp_pkg.sv */
package rsp_pkg;

  localparam int COORD_W   = 32;
  localparam int OC_W      = COORD_W + 1;
  localparam int MAX_ITEMS = 65536;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int IDX_W     = 16;
  localparam int DIST_W    = 32;
  localparam int UNIT_W    = 18;
  localparam int DIV_STEPS = 48;
  localparam int SQ_STEPS  = 32;
  localparam int STEP_W    = 6;

  // queue depth must be a power of two (pointers wrap naturally)
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FALLBACK    = 3'd6;

  typedef struct packed {
    logic signed [OC_W-1:0] oc_x;
    logic signed [OC_W-1:0] oc_y;
    logic signed [OC_W-1:0] oc_z;
    logic [COORD_W-1:0]     radius;
    logic                   rad_ok;
    logic                   last;
  } item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic              push;
    logic              found;
    logic [IDX_W-1:0]  index;
    logic [DIST_W-1:0] distance;
    logic              ovf;
  } result_t;

endpackage

/* hdl/rsp_front.sv */
`include "assert_macros.svh"
module rsp_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic signed [31:0]           center_x,
  input  logic signed [31:0]           center_y,
  input  logic signed [31:0]           center_z,
  input  logic signed [31:0]           sphere_radius,
  input  logic                         radius_present,
  input  logic                         last,
  input  rsp_pkg::vec_t                origin,
  input  logic signed [31:0]           fallback_radius,
  output rsp_pkg::item_t               item,
  output logic                         item_valid,
  input  logic                         item_pop
);
  import rsp_pkg::*;

  item_t               mem [QDEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QPTR_W:0]     count;
  logic                wr_en;
  logic                rd_en;
  logic signed [31:0]  r_sel;
  item_t               cls;

  assign full       = (count == (QPTR_W + 1)'(QDEPTH));
  assign item_valid = (count != '0);
  assign wr_en      = push && !full;
  assign rd_en      = item_pop && item_valid;
  assign item       = mem[rptr];

  always_comb begin
    r_sel = (radius_present && sphere_radius > 0) ? sphere_radius : fallback_radius;
    cls.oc_x   = OC_W'(center_x) - OC_W'(origin.x);
    cls.oc_y   = OC_W'(center_y) - OC_W'(origin.y);
    cls.oc_z   = OC_W'(center_z) - OC_W'(origin.z);
    cls.radius = r_sel;
    cls.rad_ok = (r_sel > 0);
    cls.last   = last;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr_en) begin
        wptr <= wptr + 1'b1;
      end
      if (rd_en) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `RSP_ASSERT(a_count_bound, clk, rst, count <= (QPTR_W + 1)'(QDEPTH))

endmodule

/* hdl/rsp_sqrt.sv */
module rsp_sqrt (
  input  logic                clk,
  input  logic                rst,
  input  rsp_pkg::sqrt_req_t  req,
  output rsp_pkg::sqrt_rsp_t  rsp
);
  import rsp_pkg::*;

  logic [63:0]       x;
  logic [33:0]       rem;
  logic [31:0]       root;
  logic [STEP_W-1:0] cnt;
  logic              done;
  logic [35:0]       rs;
  logic [35:0]       trial;
  logic              ge;
  logic [35:0]       diff;

  assign rs    = {rem, x[63:62]};
  assign trial = {2'b00, root, 2'b01};
  assign ge    = (rs >= trial);
  assign diff  = rs - trial;

  assign rsp.done = done;
  assign rsp.root = root;

  // one result bit per cycle, restoring
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      x    <= req.operand;
      rem  <= '0;
      root <= '0;
      cnt  <= STEP_W'(SQ_STEPS);
      done <= 1'b0;
    end else if (cnt != '0) begin
      x    <= {x[61:0], 2'b00};
      rem  <= ge ? diff[33:0] : rs[33:0];
      root <= {root[30:0], ge};
      cnt  <= cnt - 1'b1;
      done <= (cnt == STEP_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

endmodule

/* hdl/rsp_engine.sv */
`include "assert_macros.svh"
module rsp_engine (
  input  logic                clk,
  input  logic                rst,
  input  rsp_pkg::item_t      item,
  input  logic                item_valid,
  output logic                item_pop,
  input  rsp_pkg::vec_t       dir,
  output rsp_pkg::sqrt_req_t  sq_req,
  input  rsp_pkg::sqrt_rsp_t  sq_rsp,
  input  logic                res_free,
  output rsp_pkg::result_t    res
);
  import rsp_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_LEN_MUL   = 17'h00002,
    S_LEN_ACC   = 17'h00004,
    S_LEN_START = 17'h00008,
    S_LEN_WAIT  = 17'h00010,
    S_DIV_START = 17'h00020,
    S_DIV_RUN   = 17'h00040,
    S_DIV_END   = 17'h00080,
    S_ITEM      = 17'h00100,
    S_DOT_MUL   = 17'h00200,
    S_DOT_ACC   = 17'h00400,
    S_SQ_MUL    = 17'h00800,
    S_SQ_ACC    = 17'h01000,
    S_SQ_SUM    = 17'h02000,
    S_CMP       = 17'h04000,
    S_HALF_WAIT = 17'h08000,
    S_FINISH    = 17'h10000
  } state_t;

  localparam logic [57:0] CHORD_CAP = 58'h0007FFFFFFFFFFF;

  state_t                    state;
  item_t                     cur;
  logic [1:0]                idx;
  logic [2:0]                sj;
  logic [1:0]                sk;
  logic [63:0]               len2;
  logic [31:0]               len;
  logic [47:0]               dq;
  logic [31:0]               drem;
  logic [STEP_W-1:0]         dcnt;
  logic signed [UNIT_W-1:0]  unit_x, unit_y, unit_z;
  logic                      dir_ok;
  logic                      scan_started;
  logic [CNT_W-1:0]          item_count;
  logic                      best_found;
  logic [IDX_W-1:0]          best_pos;
  logic [DIST_W-1:0]         best_dist;
  logic                      ovf;
  logic [IDX_W-1:0]          pos;
  logic [63:0]               prod;
  logic                      psign;
  logic signed [53:0]        dot;
  logic signed [37:0]        t;
  logic [55:0]               sqacc;
  logic signed [57:0]        d2;
  logic [57:0]               r2;

  logic signed [31:0]        d_sel;
  logic signed [OC_W-1:0]    oc_sel;
  logic signed [UNIT_W-1:0]  u_sel;
  logic [31:0]               dmag, ocmag;
  logic [OC_W-1:0]           oc_neg;
  logic [UNIT_W-1:0]         u_neg;
  logic [37:0]               t_neg;
  logic [35:0]               m;
  logic [31:0]               opa, opb;
  logic [55:0]               term;
  logic signed [53:0]        prod_s, dot_next;
  logic [32:0]               rs;
  logic                      dge;
  logic [32:0]               dsub;
  logic [16:0]               q;
  logic                      d2_gt;
  logic [57:0]               diff, diff_cap;
  logic signed [38:0]        t_ext, half_s, tph, hit;
  logic [DIST_W-1:0]         hit_dist;

  always_comb begin
    case (idx)
      2'd0:    begin d_sel = dir.x; oc_sel = cur.oc_x; u_sel = unit_x; end
      2'd1:    begin d_sel = dir.y; oc_sel = cur.oc_y; u_sel = unit_y; end
      default: begin d_sel = dir.z; oc_sel = cur.oc_z; u_sel = unit_z; end
    endcase
    dmag   = d_sel[31] ? 32'(-d_sel) : 32'(d_sel);
    oc_neg = -oc_sel;
    ocmag  = oc_sel[OC_W-1] ? oc_neg[31:0] : oc_sel[31:0];
    u_neg  = -u_sel;

    t_neg = -t;
    case (sj)
      3'd0:    m = 36'(cur.oc_x[OC_W-1] ? 33'(-cur.oc_x) : 33'(cur.oc_x));
      3'd1:    m = 36'(cur.oc_y[OC_W-1] ? 33'(-cur.oc_y) : 33'(cur.oc_y));
      3'd2:    m = 36'(cur.oc_z[OC_W-1] ? 33'(-cur.oc_z) : 33'(cur.oc_z));
      3'd3:    m = t[37] ? t_neg[35:0] : t[35:0];
      default: m = 36'(cur.radius);
    endcase

    // one shared multiplier; sq16(m) = h*h<<16 + 2*h*l + (l*l>>16)
    case (state)
      S_LEN_MUL: begin opa = dmag; opb = dmag; end
      S_DOT_MUL: begin
        opa = ocmag;
        opb = 32'(u_sel[UNIT_W-1] ? u_neg : u_sel);
      end
      S_SQ_MUL: begin
        case (sk)
          2'd0:    begin opa = 32'(m[35:16]); opb = 32'(m[35:16]); end
          2'd1:    begin opa = 32'(m[35:16]); opb = 32'(m[15:0]); end
          default: begin opa = 32'(m[15:0]);  opb = 32'(m[15:0]); end
        endcase
      end
      default: begin opa = '0; opb = '0; end
    endcase

    case (sk)
      2'd0:    term = {prod[39:0], 16'h0000};
      2'd1:    term = {prod[54:0], 1'b0};
      default: term = 56'(prod[63:16]);
    endcase

    prod_s   = $signed(54'(prod[48:0]));
    dot_next = psign ? dot - prod_s : dot + prod_s;

    rs   = {drem, dq[47]};
    dge  = (rs >= {1'b0, len});
    dsub = rs - {1'b0, len};
    q    = dq[16:0];

    d2_gt    = (d2 > $signed(r2));
    diff     = r2 - $unsigned(d2);
    diff_cap = (diff > CHORD_CAP) ? CHORD_CAP : diff;

    t_ext  = 39'(t);
    half_s = $signed(39'(sq_rsp.root));
    tph    = t_ext + half_s;
    hit    = t_ext - half_s;
    if (hit[38]) begin
      hit_dist = '0;
    end else if (hit[38:32] != '0) begin
      hit_dist = '1;
    end else begin
      hit_dist = hit[31:0];
    end

    sq_req.start   = (state == S_LEN_START) || ((state == S_CMP) && !d2_gt);
    sq_req.operand = (state == S_LEN_START) ? len2 : {1'b0, diff_cap[46:0], 16'h0000};

    item_pop     = (state == S_IDLE) && item_valid;
    res.push     = (state == S_FINISH) && cur.last && res_free;
    res.found    = best_found;
    res.index    = best_found ? best_pos : '0;
    res.distance = best_found ? best_dist : '0;
    res.ovf      = ovf;
  end

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      scan_started <= 1'b0;
      dir_ok       <= 1'b0;
      unit_x       <= '0;
      unit_y       <= '0;
      unit_z       <= '0;
      item_count   <= '0;
      best_found   <= 1'b0;
      best_pos     <= '0;
      best_dist    <= '1;
      ovf          <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (item_valid) begin
            cur <= item;
            if (scan_started) begin
              state <= S_ITEM;
            end else begin
              scan_started <= 1'b1;
              len2         <= '0;
              idx          <= '0;
              state        <= S_LEN_MUL;
            end
          end
        end
        S_LEN_MUL: state <= S_LEN_ACC;
        S_LEN_ACC: begin
          len2 <= len2 + prod;
          if (idx == 2'd2) begin
            state <= S_LEN_START;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_LEN_MUL;
          end
        end
        S_LEN_START: state <= S_LEN_WAIT;
        S_LEN_WAIT: begin
          if (sq_rsp.done) begin
            if (sq_rsp.root == '0) begin
              // zero-length direction: nothing in this scan can hit
              dir_ok <= 1'b0;
              unit_x <= '0;
              unit_y <= '0;
              unit_z <= '0;
              state  <= S_ITEM;
            end else begin
              len   <= sq_rsp.root;
              idx   <= '0;
              state <= S_DIV_START;
            end
          end
        end
        S_DIV_START: begin
          drem  <= '0;
          dq    <= {dmag, 16'h0000};
          dcnt  <= STEP_W'(DIV_STEPS);
          state <= S_DIV_RUN;
        end
        S_DIV_RUN: begin
          drem <= dge ? dsub[31:0] : rs[31:0];
          dq   <= {dq[46:0], dge};
          dcnt <= dcnt - 1'b1;
          if (dcnt == STEP_W'(1)) begin
            state <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          case (idx)
            2'd0:    unit_x <= d_sel[31] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            2'd1:    unit_y <= d_sel[31] ? -$signed({1'b0, q}) : $signed({1'b0, q});
            default: unit_z <= d_sel[31] ? -$signed({1'b0, q}) : $signed({1'b0, q});
          endcase
          if (idx == 2'd2) begin
            dir_ok <= 1'b1;
            state  <= S_ITEM;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_DIV_START;
          end
        end
        S_ITEM: begin
          if (item_count >= CNT_W'(MAX_ITEMS)) begin
            ovf   <= 1'b1;
            state <= S_FINISH;
          end else begin
            item_count <= item_count + 1'b1;
            pos        <= item_count[IDX_W-1:0];
            if (dir_ok && cur.rad_ok) begin
              idx   <= '0;
              dot   <= '0;
              state <= S_DOT_MUL;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_DOT_MUL: begin
          psign <= oc_sel[OC_W-1] ^ u_sel[UNIT_W-1];
          state <= S_DOT_ACC;
        end
        S_DOT_ACC: begin
          dot <= dot_next;
          if (idx == 2'd2) begin
            t     <= dot_next[53:16];
            sj    <= '0;
            sk    <= '0;
            sqacc <= '0;
            d2    <= '0;
            r2    <= '0;
            state <= S_SQ_MUL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_DOT_MUL;
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          sqacc <= sqacc + term;
          if (sk == 2'd2) begin
            state <= S_SQ_SUM;
          end else begin
            sk    <= sk + 1'b1;
            state <= S_SQ_MUL;
          end
        end
        S_SQ_SUM: begin
          case (sj)
            3'd3:    d2 <= d2 - $signed(58'(sqacc));
            3'd4:    r2 <= 58'(sqacc);
            default: d2 <= d2 + $signed(58'(sqacc));
          endcase
          sqacc <= '0;
          sk    <= '0;
          if (sj == 3'd4) begin
            state <= S_CMP;
          end else begin
            sj    <= sj + 1'b1;
            state <= S_SQ_MUL;
          end
        end
        S_CMP: state <= d2_gt ? S_FINISH : S_HALF_WAIT;
        S_HALF_WAIT: begin
          if (sq_rsp.done) begin
            // exit point must not lie behind the origin; ties keep the first
            if (!tph[38] && (!best_found || hit_dist < best_dist)) begin
              best_found <= 1'b1;
              best_pos   <= pos;
              best_dist  <= hit_dist;
            end
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!cur.last) begin
            state <= S_IDLE;
          end else if (res_free) begin
            scan_started <= 1'b0;
            item_count   <= '0;
            best_found   <= 1'b0;
            best_pos     <= '0;
            best_dist    <= '1;
            ovf          <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RSP_ASSERT(a_sqrt_done_waited, clk, rst, sq_rsp.done |-> (state == S_LEN_WAIT || state == S_HALF_WAIT))
  `RSP_ASSERT(a_idle_scan_clear, clk, rst, !scan_started |-> (item_count == '0 && !best_found && !ovf))

endmodule

/* hdl/nearest_ray_sphere_pick.sv */
// Nearest ray/sphere pick, Q16.16 fixed point.
//
// Config: write origin_x/y/z (index 0..2), direction_x/y/z (3..5) and
// fallback_radius (6) through cfg_valid/cfg_ready/cfg_index/cfg_data; only
// while the block is idle. cfg_ready is always high. Direction is latched
// when the first sphere of a scan starts.
// Input: push one sphere per transfer while full is low; last closes a scan.
// Output: one result per scan, shown while empty is low, taken by pop.
// Timing: a two-entry input queue decouples the classifier from the
// sequencer. A sphere that is tested takes three multiply-accumulates
// for the dot product and fifteen for the squares on the one shared
// 32x32 multiplier, then, unless it misses, the bit-serial square root.
// Spheres skipped (overflow, zero direction, no radius) go straight to finish.
// The first sphere of a scan first normalizes the direction: one square
// root and, for a nonzero length, three bit-serial divisions.
// The result is registered from the last sphere's finish step.
// If the result is not popped, the next scan's last sphere waits; the
// queue fills and full rises. Reset clears the scan and the registers.
`include "assert_macros.svh"
module nearest_ray_sphere_pick (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic signed [31:0]                center_x,
  input  logic signed [31:0]                center_y,
  input  logic signed [31:0]                center_z,
  input  logic signed [31:0]                sphere_radius,
  input  logic                              radius_present,
  input  logic                              last,
  output logic                              empty,
  input  logic                              pop,
  output logic                              found,
  output logic [15:0]                       best_index,
  output logic [31:0]                       hit_distance,
  output logic                              overflow,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import rsp_pkg::*;

  vec_t               origin;
  vec_t               dir;
  logic signed [31:0] fallback;
  item_t              item;
  logic               item_valid;
  logic               item_pop;
  sqrt_req_t          sq_req;
  sqrt_rsp_t          sq_rsp;
  result_t            res;
  logic               res_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !res_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin   <= '0;
      dir      <= '0;
      fallback <= 32'sd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:    origin.x <= cfg_data;
        REG_ORIGIN_Y:    origin.y <= cfg_data;
        REG_ORIGIN_Z:    origin.z <= cfg_data;
        REG_DIRECTION_X: dir.x    <= cfg_data;
        REG_DIRECTION_Y: dir.y    <= cfg_data;
        REG_DIRECTION_Z: dir.z    <= cfg_data;
        REG_FALLBACK:    fallback <= cfg_data;
        default:         ;
      endcase
    end
  end

  rsp_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .full            (full),
    .center_x        (center_x),
    .center_y        (center_y),
    .center_z        (center_z),
    .sphere_radius   (sphere_radius),
    .radius_present  (radius_present),
    .last            (last),
    .origin          (origin),
    .fallback_radius (fallback),
    .item            (item),
    .item_valid      (item_valid),
    .item_pop        (item_pop)
  );

  rsp_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sq_req),
    .rsp (sq_rsp)
  );

  rsp_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .dir        (dir),
    .sq_req     (sq_req),
    .sq_rsp     (sq_rsp),
    .res_free   (!res_valid),
    .res        (res)
  );

  // result holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res.push) begin
      res_valid <= 1'b1;
    end else if (pop && res_valid) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.push) begin
      found        <= res.found;
      best_index   <= res.index;
      hit_distance <= res.distance;
      overflow     <= res.ovf;
    end
  end

  `RSP_ASSERT(a_no_overwrite, clk, rst, res.push |-> !res_valid)
  `RSP_ASSERT_NEXT(a_pop_drains, clk, rst, pop && res_valid && !res.push, !res_valid)

endmodule

/* tb/sv/pick_checker.sv */
`timescale 1ns / 1ps
module pick_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  logic                          full,
  input  logic signed [31:0]            center_x,
  input  logic signed [31:0]            center_y,
  input  logic signed [31:0]            center_z,
  input  logic signed [31:0]            sphere_radius,
  input  logic                          radius_present,
  input  logic                          last,
  input  logic                          empty,
  input  logic                          pop,
  input  logic                          found,
  input  logic [15:0]                   best_index,
  input  logic [31:0]                   hit_distance,
  input  logic                          overflow,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [rsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  output int                            fail_count,
  output int                            pending
);
  import rsp_pkg::*;

  localparam longint unsigned CHORD_CAP = (64'd1 << 47) - 1;

  typedef struct {
    bit        found;
    bit [15:0] index;
    bit [31:0] distance;
    bit        ovf;
  } pick_t;

  pick_t pick_q[$];
  int fails = 0;

  // ray registers
  logic signed [31:0] org[3];
  logic signed [31:0] dir[3];
  logic signed [31:0] fb_radius;
  // scan state
  longint unit[3];
  bit     dir_ok;
  bit     started;
  int     count;
  bit     have_best;
  bit [15:0] best_pos;
  bit [31:0] best_dist;
  bit     ovf_seen;

  assign fail_count = fails;

  function automatic longint unsigned isqrt(longint unsigned x);
    longint unsigned res, bits;
    res = 0;
    bits = 64'd1 << 62;
    while (bits > x) bits = bits >> 2;
    while (bits != 0) begin
      if (x >= res + bits) begin
        x = x - (res + bits);
        res = (res >> 1) + bits;
      end else begin
        res = res >> 1;
      end
      bits = bits >> 2;
    end
    return res;
  endfunction

  function automatic longint sq_q16(longint a);
    logic [127:0] m, p;
    m = (a < 0) ? 128'(-a) : 128'(a);
    p = (m * m) >> 16;
    return longint'(p[63:0]);
  endfunction

  task automatic clear_scan();
    started = 0;
    count = 0;
    have_best = 0;
    best_pos = '0;
    best_dist = '1;
    ovf_seen = 0;
  endtask

  task automatic latch_direction();
    longint unsigned len2, len, mg, q;
    len2 = 0;
    for (int i = 0; i < 3; i++) begin
      mg = dir[i] < 0 ? longint'(-longint'(dir[i])) : longint'(dir[i]);
      len2 = len2 + mg * mg;
    end
    len = isqrt(len2);
    dir_ok = (len != 0);
    for (int i = 0; i < 3; i++) begin
      mg = dir[i] < 0 ? longint'(-longint'(dir[i])) : longint'(dir[i]);
      q = (len == 0) ? 0 : (mg << 16) / len;
      unit[i] = dir[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic test_sphere(logic signed [31:0] c[3], logic signed [31:0] rad, bit rp);
    longint oc[3], dot, t, d2, r, r2, diff, hit;
    longint unsigned half;
    bit [31:0] hit_dist;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      oc[i] = longint'(c[i]) - longint'(org[i]);
      dot = dot + oc[i] * unit[i];
    end
    t = dot >>> 16;
    r = (rp && rad > 0) ? longint'(rad) : longint'(fb_radius);
    if (r <= 0) return;
    r2 = sq_q16(r);
    d2 = sq_q16(oc[0]) + sq_q16(oc[1]) + sq_q16(oc[2]) - sq_q16(t);
    if (d2 > r2) return;
    diff = r2 - d2;
    if (longint'(diff) > longint'(CHORD_CAP)) diff = CHORD_CAP;
    half = isqrt(longint'(diff) << 16);
    if (t + longint'(half) < 0) return;
    hit = t - longint'(half);
    if (hit < 0) hit = 0;
    hit_dist = (hit > 64'hFFFFFFFF) ? 32'hFFFFFFFF : hit[31:0];
    if (!have_best || hit_dist < best_dist) begin
      have_best = 1;
      best_pos = count[15:0];
      best_dist = hit_dist;
    end
  endtask

  task automatic pick_sphere();
    logic signed [31:0] c[3];
    pick_t p;
    c[0] = center_x;
    c[1] = center_y;
    c[2] = center_z;
    if (!started) begin
      latch_direction();
      started = 1;
    end
    if (count >= MAX_ITEMS) begin
      ovf_seen = 1;
    end else begin
      if (dir_ok) test_sphere(c, sphere_radius, radius_present);
      count++;
    end
    if (last) begin
      p.found    = have_best;
      p.index    = have_best ? best_pos : 16'd0;
      p.distance = have_best ? best_dist : 32'd0;
      p.ovf      = ovf_seen;
      pick_q.push_back(p);
      clear_scan();
    end
  endtask

  always @(posedge clk) begin
    pick_t e;
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        org[i] = '0;
        dir[i] = '0;
        unit[i] = 0;
      end
      fb_radius = 32'sd65536;
      dir_ok = 0;
      clear_scan();
      pick_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ORIGIN_X:    org[0] = cfg_data;
          REG_ORIGIN_Y:    org[1] = cfg_data;
          REG_ORIGIN_Z:    org[2] = cfg_data;
          REG_DIRECTION_X: dir[0] = cfg_data;
          REG_DIRECTION_Y: dir[1] = cfg_data;
          REG_DIRECTION_Z: dir[2] = cfg_data;
          REG_FALLBACK:    fb_radius = cfg_data;
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (pick_q.size() == 0) begin
          $display("%0t: result with nothing expected: found %0b index %0d dist %h ovf %0b",
                   $time, found, best_index, hit_distance, overflow);
          fails++;
        end else begin
          e = pick_q.pop_front();
          if (found !== e.found) begin
            $display("%0t: found expected %0b actual %0b", $time, e.found, found);
            fails++;
          end
          if (best_index !== e.index) begin
            $display("%0t: best_index expected %0d actual %0d", $time, e.index, best_index);
            fails++;
          end
          if (hit_distance !== e.distance) begin
            $display("%0t: hit_distance expected %h actual %h", $time, e.distance,
                     hit_distance);
            fails++;
          end
          if (overflow !== e.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, overflow);
            fails++;
          end
        end
      end
      // input transfer after output: a result never leaves in the cycle its last sphere enters
      if (push && !full) pick_sphere();
    end
    pending = pick_q.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
module tb;
  import rsp_pkg::*;

  localparam int LIMIT    = 3000000;
  localparam int SETTLE   = 400;
  localparam int ONE      = 65536;

  logic clk = 0;
  logic rst = 1;
  logic push = 0;
  logic signed [31:0] center_x = 0, center_y = 0, center_z = 0, sphere_radius = 0;
  logic radius_present = 0, last = 0;
  logic pop = 0;
  logic cfg_valid = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = 0;
  logic full, empty, found, overflow, cfg_ready;
  logic [15:0] best_index;
  logic [31:0] hit_distance;
  int fail_count, pending;

  longint cur_org[3];
  longint cur_dir[3];
  bit     no_idle = 0;
  bit     hold_req = 0;
  bit     hold_done = 0;
  int     hold_left = 0;
  int     pop_gap = 0;
  int     cycles = 0;
  int     spheres = 0;
  int     scans = 0;
  int     settings = 0;

  always #2 clk = ~clk;

  nearest_ray_sphere_pick u_dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .sphere_radius(sphere_radius), .radius_present(radius_present), .last(last),
    .empty(empty), .pop(pop), .found(found), .best_index(best_index),
    .hit_distance(hit_distance), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  pick_checker u_chk (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .center_x(center_x), .center_y(center_y), .center_z(center_z),
    .sphere_radius(sphere_radius), .radius_present(radius_present), .last(last),
    .empty(empty), .pop(pop), .found(found), .best_index(best_index),
    .hit_distance(hit_distance), .overflow(overflow),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len(bit long_ok);
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (long_ok && r > 97) return $urandom_range(60, 250);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      pop <= 0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      pop <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done = 1;
      hold_left = 3000;
      pop <= 0;
    end else begin
      if (pop && !empty) pop_gap = gap_len(1);
      if (pop_gap > 0) begin
        pop_gap = pop_gap - 1;
        pop <= 0;
      end else begin
        pop <= 1;
      end
    end
  end

  task automatic send(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                      logic [31:0] r, bit rp, bit lst);
    int g;
    push <= 1;
    center_x <= cx;
    center_y <= cy;
    center_z <= cz;
    sphere_radius <= r;
    radius_present <= rp;
    last <= lst;
    do @(posedge clk); while (full);
    spheres++;
    if (lst) scans++;
    g = gap_len(0);
    if (g > 0) begin
      push <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X:    cur_org[0] = longint'($signed(val));
      REG_ORIGIN_Y:    cur_org[1] = longint'($signed(val));
      REG_ORIGIN_Z:    cur_org[2] = longint'($signed(val));
      REG_DIRECTION_X: cur_dir[0] = longint'($signed(val));
      REG_DIRECTION_Y: cur_dir[1] = longint'($signed(val));
      REG_DIRECTION_Z: cur_dir[2] = longint'($signed(val));
      default: ;
    endcase
  endtask

  task automatic drain();
    push <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_ray(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                         logic [31:0] dx, logic [31:0] dy, logic [31:0] dz,
                         logic [31:0] fb);
    drain();
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_DIRECTION_X, dx);
    write_reg(REG_DIRECTION_Y, dy);
    write_reg(REG_DIRECTION_Z, dz);
    write_reg(REG_FALLBACK, fb);
    cfg_valid <= 0;
    settings++;
  endtask

  // sphere near the ray most of the time, raw noise otherwise
  task automatic random_sphere(bit lst);
    longint s, c[3];
    logic [31:0] r;
    if ($urandom_range(99) < 20) begin
      send($urandom, $urandom, $urandom, $urandom, 1'($urandom_range(1)), lst);
    end else begin
      s = longint'($urandom_range(0, 96 * ONE)) - 32 * ONE;
      for (int i = 0; i < 3; i++)
        c[i] = cur_org[i] + ((s * cur_dir[i]) >>> 16)
               + longint'($urandom_range(0, 8 * ONE)) - 4 * ONE;
      r = $urandom_range(ONE / 4, 6 * ONE);
      if ($urandom_range(9) == 0) r = -r;
      send(c[0][31:0], c[1][31:0], c[2][31:0], r, $urandom_range(9) != 0, lst);
    end
  endtask

  task automatic random_scans(int n);
    int k;
    while (n > 0) begin
      k = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
      for (int i = 0; i < k; i++) random_sphere(i == k - 1);
      n = n - k;
    end
  endtask

  initial begin
    logic [31:0] dx, dy, dz;
    for (int i = 0; i < 3; i++) begin
      cur_org[i] = 0;
      cur_dir[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset registers: zero direction, nothing can hit
    send(0, 0, 0, 32'h7FFFFFFF, 1, 0);
    send(32'h80000000, 32'h7FFFFFFF, 0, ONE, 1, 1);

    set_ray(0, 0, 0, ONE, 0, 0, ONE);
    send(10 * ONE, 0, 0, 2 * ONE, 1, 1);            // plain hit, entry at 8
    send(20 * ONE, 0, 0, ONE, 1, 0);
    send(10 * ONE, 0, 0, ONE, 1, 0);                // tie pair, first wins
    send(10 * ONE, 0, 0, ONE, 1, 1);
    send(-10 * ONE, 0, 0, 2 * ONE, 1, 0);           // behind the origin
    send(ONE / 2, 0, 0, 2 * ONE, 1, 1);             // origin inside: clamped to zero
    send(30 * ONE, 0, 0, 5 * ONE, 0, 0);            // radius not given
    send(40 * ONE, 0, 0, -3 * ONE, 1, 0);           // negative radius, fallback
    send(50 * ONE, 0, 0, 0, 1, 1);
    send(10 * ONE, 5 * ONE, 0, ONE, 1, 0);          // perpendicular miss
    send(10 * ONE, ONE, 0, ONE, 1, 1);              // tangent
    send(32'h7FFFFFFF, 0, 0, 32'h7FFFFFFF, 1, 0);
    send(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 1, 0);
    send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 1);

    set_ray(32'h80000000, 32'h80000000, 32'h80000000,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, ONE, 0, 0);
    send(0, 0, 0, 32'h7FFFFFFF, 1, 1);

    set_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
    send(0, 0, 0, ONE, 0, 0);                       // fallback unusable
    send(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 1, 1);

    set_ray(0, 0, 0, 0, 0, -ONE, 0);
    send(0, 0, -5 * ONE, 0, 0, 1);                  // zero fallback, no radius
    send(0, 0, -5 * ONE, ONE, 1, 1);

    // output held off while spheres keep coming
    set_ray(0, 0, 0, 0, ONE, 0, 2 * ONE);
    hold_req <= 1;
    for (int i = 0; i < 24; i++) random_sphere(1);

    for (int p = 0; p < 10; p++) begin
      if (p % 3 == 2) begin
        dx = $urandom;
        dy = $urandom;
        dz = $urandom;
      end else begin
        dx = $urandom_range(0, 8 * ONE) - 4 * ONE;
        dy = $urandom_range(0, 8 * ONE) - 4 * ONE;
        dz = $urandom_range(0, 8 * ONE) - 4 * ONE;
      end
      set_ray($urandom_range(0, 200 * ONE) - 100 * ONE,
              $urandom_range(0, 200 * ONE) - 100 * ONE,
              (p % 4 == 3) ? $urandom : $urandom_range(0, 200 * ONE) - 100 * ONE,
              dx, dy, dz,
              (p % 5 == 4) ? $urandom : $urandom_range(1, 4 * ONE));
      no_idle = (p % 4 == 1);
      random_scans(60);
    end
    no_idle = 0;

    drain();
    $display("Checked %0d spheres in %0d scans over %0d ray settings,", spheres, scans,
             settings);
    $display("including a zero direction, extreme coordinates and a long output stall.");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
